@@ src/oerc_pkg.sv @@
`timescale 1ns / 1ps
package oerc_pkg;

  localparam int RING_DEPTH_DEF  = 1024;
  localparam int NUM_READERS_DEF = 4;
  localparam int DATA_WIDTH_DEF  = 64;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    OP_EMIT   = 2'd0,
    OP_TAKE   = 2'd1,
    OP_ATTACH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_EMIT,
    CMD_TAKE,
    CMD_ATTACH,
    CMD_NONE
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TAKE,
    BK_READ
  } back_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  reader_id;
    logic [63:0] event_data;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [63:0] sequence_res;
    logic [63:0] event_out;
    logic [31:0] lost_count;
    logic        pending;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        rid_ok;
    logic [1:0]  reader_id;
    logic [63:0] event_data;
  } cmd_t;

endpackage

@@ src/oerc_ram.sv @@
`timescale 1ns / 1ps
module oerc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/oerc_front.sv @@
`timescale 1ns / 1ps
module oerc_front #(
  parameter int NUM_READERS = oerc_pkg::NUM_READERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  oerc_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i,
  output oerc_pkg::cmd_t     cmd_o
);
  import oerc_pkg::*;

  cmd_t       q_mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  cmd_t       cls;

  // classify the incoming beat
  always_comb begin
    cls.rid_ok     = 32'(in_data_i.reader_id) < 32'(NUM_READERS);
    cls.reader_id  = in_data_i.reader_id;
    cls.event_data = in_data_i.event_data;
    case (in_data_i.operation)
      OP_EMIT:   cls.kind = CMD_EMIT;
      OP_TAKE:   cls.kind = CMD_TAKE;
      OP_ATTACH: cls.kind = CMD_ATTACH;
      default:   cls.kind = CMD_NONE;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = q_mem_q[rptr_q];

  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = cmd_pop_i ? ~rptr_q : rptr_q;
    count_d = count_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= cls;
    end
  end

endmodule

@@ src/oerc_back.sv @@
`timescale 1ns / 1ps
module oerc_back #(
  parameter int RING_DEPTH  = oerc_pkg::RING_DEPTH_DEF,
  parameter int NUM_READERS = oerc_pkg::NUM_READERS_DEF,
  parameter int DATA_WIDTH  = oerc_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  oerc_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output oerc_pkg::out_item_t out_data_o
);
  import oerc_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int RIDX_W = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  back_state_e       state_q, state_d;
  logic [63:0]       wseq_q, wseq_d;
  logic [SLOT_W-1:0] wslot_q, wslot_d;
  logic [63:0]       oldest_q;
  logic [SLOT_W-1:0] oldest_slot_q;
  logic [63:0]       cur_q [NUM_READERS];
  logic [63:0]       cur_d [NUM_READERS];
  logic [SLOT_W-1:0] cslot_q [NUM_READERS];
  logic [SLOT_W-1:0] cslot_d [NUM_READERS];
  logic [RIDX_W-1:0] ridx_q, ridx_d, ridx_in;
  logic [63:0]       seq_q, seq_d;
  logic [31:0]       lost_q, lost_d;
  logic              out_valid_q;
  out_item_t         out_q, res;
  logic              out_load, out_free;
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [63:0]       cur_sel, eff;
  logic [SLOT_W-1:0] eff_slot;
  logic              late;

  oerc_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wslot_q),
    .wdata_i(DATA_WIDTH'(cmd_i.event_data)),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign ridx_in  = RIDX_W'(cmd_i.reader_id);
  assign cur_sel  = cur_q[ridx_q];
  assign late     = cur_sel < oldest_q;
  assign eff      = late ? oldest_q : cur_sel;
  assign eff_slot = late ? oldest_slot_q : cslot_q[ridx_q];

  always_comb begin
    state_d   = state_q;
    wseq_d    = wseq_q;
    wslot_d   = wslot_q;
    cur_d     = cur_q;
    cslot_d   = cslot_q;
    ridx_d    = ridx_q;
    seq_d     = seq_q;
    lost_d    = lost_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = eff_slot;
    out_load  = 1'b0;
    res       = '0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          ridx_d    = ridx_in;
          case (cmd_i.kind)
            CMD_EMIT: begin
              ram_we           = 1'b1;
              wseq_d           = wseq_q + 64'd1;
              wslot_d          = slot_inc(wslot_q);
              out_load         = 1'b1;
              res.sequence_res = wseq_q;
              res.pending      = cmd_i.rid_ok && (cur_q[ridx_in] != wseq_q + 64'd1);
            end
            CMD_ATTACH: begin
              if (cmd_i.rid_ok) begin
                cur_d[ridx_in]   = wseq_q;
                cslot_d[ridx_in] = wslot_q;
              end
              out_load = 1'b1;
            end
            CMD_TAKE: begin
              if (cmd_i.rid_ok) begin
                state_d = BK_TAKE;
              end else begin
                out_load   = 1'b1;
                res.status = ST_EMPTY;
              end
            end
            default: begin
              out_load    = 1'b1;
              res.pending = cmd_i.rid_ok && (cur_q[ridx_in] != wseq_q);
            end
          endcase
        end
      end
      BK_TAKE: begin
        if (cur_sel == wseq_q) begin
          out_load   = 1'b1;
          res.status = ST_EMPTY;
          state_d    = BK_IDLE;
        end else begin
          ram_re          = 1'b1;
          seq_d           = eff;
          lost_d          = late ? 32'(oldest_q - cur_sel) : 32'd0;
          cur_d[ridx_q]   = eff + 64'd1;
          cslot_d[ridx_q] = slot_inc(eff_slot);
          state_d         = BK_READ;
        end
      end
      BK_READ: begin
        out_load         = 1'b1;
        res.status       = ST_DONE;
        res.sequence_res = seq_q;
        res.event_out    = 64'(ram_rdata);
        res.lost_count   = lost_q;
        res.pending      = cur_sel != wseq_q;
        state_d          = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wseq_q        <= 64'd1;
      wslot_q       <= SLOT_W'(1);
      oldest_q      <= 64'd1;
      oldest_slot_q <= SLOT_W'(1);
      for (int i = 0; i < NUM_READERS; i++) begin
        cur_q[i]   <= 64'd1;
        cslot_q[i] <= SLOT_W'(1);
      end
      out_valid_q <= 1'b0;
    end else begin
      wseq_q  <= wseq_d;
      wslot_q <= wslot_d;
      // oldest retained sequence is registered from the write sequence, so it trails it
      if (wseq_q > 64'(RING_DEPTH)) begin
        oldest_q      <= wseq_q - 64'(RING_DEPTH);
        oldest_slot_q <= wslot_q;
      end else begin
        oldest_q      <= 64'd1;
        oldest_slot_q <= SLOT_W'(1);
      end
      cur_q   <= cur_d;
      cslot_q <= cslot_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d;
    seq_q  <= seq_d;
    lost_q <= lost_d;
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/overwrite_event_ring_reader_cursors.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake              | beat
// in      | input     | in_valid_i / in_stall_o   | oerc_pkg::in_item_t
// out     | output    | out_valid_o / out_stall_i | oerc_pkg::out_item_t
//
// a two-entry queue takes one beat per cycle while it has room
// emit, attach, unused ops and takes for a missing reader are answered from the idle state
// a take steps through dispatch, cursor check with ring ram read and result, or skips the result step when empty
// reset sets write sequence and all cursors to one; ring contents stay undefined
// a result waits in the output register under stall while the queue keeps filling
module overwrite_event_ring_reader_cursors #(
  parameter int RING_DEPTH  = oerc_pkg::RING_DEPTH_DEF,
  parameter int NUM_READERS = oerc_pkg::NUM_READERS_DEF,
  parameter int DATA_WIDTH  = oerc_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  oerc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output oerc_pkg::out_item_t out_data_o
);
  import oerc_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  oerc_front #(
    .NUM_READERS(NUM_READERS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(q_valid),
    .cmd_pop_i  (q_pop),
    .cmd_o      (q_cmd)
  );

  oerc_back #(
    .RING_DEPTH (RING_DEPTH),
    .NUM_READERS(NUM_READERS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_pop_o  (q_pop),
    .cmd_i      (q_cmd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!out_valid_o || !out_stall_i))
    else $error("queue popped while output register blocked");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_pop) |=> q_valid)
    else $error("queue head lost without pop");

  a_empty_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_EMPTY) |-> !out_data_o.pending)
    else $error("empty take reports pending events");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import oerc_pkg::*;

  localparam int DEPTH       = RING_DEPTH_DEF;
  localparam int READERS     = NUM_READERS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PLAN_ROWS   = 18;

  typedef struct packed {
    in_item_t  beat;
    logic      known;
    out_item_t want;
  } plan_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  logic [63:0] ring_copy [DEPTH];
  logic [63:0] next_seq;
  logic [63:0] cursor_copy [READERS];
  out_item_t   predicted_results [$];
  plan_row_t   plan [PLAN_ROWS];

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  overwrite_event_ring_reader_cursors dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t ring_step(input in_item_t beat);
    out_item_t   res;
    logic [63:0] cur;
    logic [63:0] oldest;
    res = '0;
    res.status = ST_DONE;
    case (op_e'(beat.operation))
      OP_EMIT: begin
        res.sequence_res = next_seq;
        ring_copy[next_seq % DEPTH] = beat.event_data;
        next_seq = next_seq + 64'd1;
      end
      OP_TAKE: begin
        cur = cursor_copy[beat.reader_id];
        if (cur == next_seq) begin
          res.status = ST_EMPTY;
        end else begin
          oldest = (next_seq > 64'(DEPTH)) ? next_seq - 64'(DEPTH) : 64'd1;
          if (cur < oldest) begin
            res.lost_count = 32'(oldest - cur);
            cur = oldest;
          end
          res.event_out = ring_copy[cur % DEPTH];
          res.sequence_res = cur;
          cursor_copy[beat.reader_id] = cur + 64'd1;
        end
      end
      OP_ATTACH: begin
        cursor_copy[beat.reader_id] = next_seq;
      end
      default: begin
      end
    endcase
    res.pending = (cursor_copy[beat.reader_id] != next_seq);
    return res;
  endfunction

  // emits dominate; reader 3 is never attached here, so its cursor falls out of the ring
  function automatic in_item_t random_beat();
    in_item_t    beat;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    beat.event_data = {$urandom, $urandom};
    beat.reader_id = 2'($urandom_range(3));
    if (roll < 75) begin
      beat.operation = OP_EMIT;
    end else if (roll < 93) begin
      beat.operation = OP_TAKE;
      beat.reader_id = (pick < 40) ? 2'd0 : (pick < 65) ? 2'd1 : (pick < 80) ? 2'd2 : 2'd3;
    end else if (roll < 97) begin
      beat.operation = OP_ATTACH;
      beat.reader_id = 2'($urandom_range(2));
    end else begin
      beat.operation = OP_NONE;
    end
    return beat;
  endfunction

  task automatic send_beat(input in_item_t beat, input logic known, input out_item_t want);
    out_item_t model_res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = beat;
    do @(posedge clk_i); while (in_stall_o);
    model_res = ring_step(beat);
    predicted_results.push_back(known ? want : model_res);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned s_pct,
                              input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_beat(random_beat(), 1'b0, '0);
    drain();
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_item_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_res = predicted_results.pop_front();
        if (out_data_o.status !== exp_res.status) begin
          $error("status expected %0h got %0h", exp_res.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.sequence_res !== exp_res.sequence_res) begin
          $error("sequence_res expected %0h got %0h", exp_res.sequence_res,
                 out_data_o.sequence_res);
          errors++;
        end
        if (out_data_o.event_out !== exp_res.event_out) begin
          $error("event_out expected %0h got %0h", exp_res.event_out, out_data_o.event_out);
          errors++;
        end
        if (out_data_o.lost_count !== exp_res.lost_count) begin
          $error("lost_count expected %0h got %0h", exp_res.lost_count,
                 out_data_o.lost_count);
          errors++;
        end
        if (out_data_o.pending !== exp_res.pending) begin
          $error("pending expected %0h got %0h", exp_res.pending, out_data_o.pending);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("overwrite_event_ring_reader_cursors: mismatch");
      $finish;
    end
  end

  initial begin
    next_seq = 64'd1;
    for (int i = 0; i < READERS; i++) cursor_copy[i] = 64'd1;
    plan = '{
      '{'{OP_TAKE,   2'd0, 64'd0}, 1'b1, '{ST_EMPTY, 64'd0, 64'd0, 32'd0, 1'b0}},
      '{'{OP_NONE,   2'd3, '1},    1'b1, '{ST_DONE,  64'd0, 64'd0, 32'd0, 1'b0}},
      '{'{OP_EMIT,   2'd0, 64'd0}, 1'b1, '{ST_DONE,  64'd1, 64'd0, 32'd0, 1'b1}},
      '{'{OP_EMIT,   2'd3, '1},    1'b1, '{ST_DONE,  64'd2, 64'd0, 32'd0, 1'b1}},
      '{'{OP_TAKE,   2'd1, 64'd0}, 1'b1, '{ST_DONE,  64'd1, 64'd0, 32'd0, 1'b1}},
      '{'{OP_TAKE,   2'd1, 64'd0}, 1'b1, '{ST_DONE,  64'd2, '1,    32'd0, 1'b0}},
      '{'{OP_TAKE,   2'd1, 64'd0}, 1'b1, '{ST_EMPTY, 64'd0, 64'd0, 32'd0, 1'b0}},
      '{'{OP_ATTACH, 2'd2, 64'd0}, 1'b1, '{ST_DONE,  64'd0, 64'd0, 32'd0, 1'b0}},
      '{'{OP_TAKE,   2'd2, 64'd0}, 1'b1, '{ST_EMPTY, 64'd0, 64'd0, 32'd0, 1'b0}},
      '{'{OP_EMIT,   2'd2, 64'h8000_0000_0000_0001}, 1'b1,
        '{ST_DONE, 64'd3, 64'd0, 32'd0, 1'b1}},
      '{'{OP_TAKE,   2'd2, 64'd0}, 1'b1,
        '{ST_DONE, 64'd3, 64'h8000_0000_0000_0001, 32'd0, 1'b0}},
      '{'{OP_ATTACH, 2'd3, 64'd0}, 1'b1, '{ST_DONE,  64'd0, 64'd0, 32'd0, 1'b0}},
      '{'{OP_NONE,   2'd0, 64'd0}, 1'b1, '{ST_DONE,  64'd0, 64'd0, 32'd0, 1'b1}},
      '{'{OP_EMIT,   2'd1, 64'h5555_5555_5555_5555}, 1'b0, '0},
      '{'{OP_TAKE,   2'd3, 64'd0}, 1'b0, '0},
      '{'{OP_TAKE,   2'd0, 64'd0}, 1'b0, '0},
      '{'{OP_ATTACH, 2'd1, 64'haaaa_aaaa_aaaa_aaaa}, 1'b0, '0},
      '{'{OP_EMIT,   2'd0, 64'haaaa_aaaa_aaaa_aaaa}, 1'b0, '0}
    };
    send_idle_pct = 18;
    recv_idle_pct = 74;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].known, plan[i].want);
    // hold off until the pipe is empty before random traffic
    drain();

    random_phase(530, 18, 74);
    random_phase(530, 74, 18);
    random_phase(540, 0, 0);

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("overwrite_event_ring_reader_cursors: match");
    end else begin
      $display("overwrite_event_ring_reader_cursors: mismatch");
    end
    $finish;
  end

endmodule
